### rtl/closest_pair_distance_assert.svh
// Assertion macros shared by the closest pair distance RTL.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef CLOSEST_PAIR_DISTANCE_ASSERT_SVH
`define CLOSEST_PAIR_DISTANCE_ASSERT_SVH

// Same-cycle implication.
`define CPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cpd_pkg.sv
`default_nettype none
package cpd_pkg;

	// Size of the point store.
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Field widths.
	localparam int COORD_W = 31;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int SQ_W    = PROD_W + 1;
	localparam int FRAC_W  = 16;
	localparam int ROOT_W  = 48;

	// Square root unit widths.
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W);

	// Sequencer states, one-hot.
	typedef enum logic [9:0] {
		S_LOAD    = 10'b00_0000_0001,
		S_IRD     = 10'b00_0000_0010,
		S_ICAP    = 10'b00_0000_0100,
		S_JRD     = 10'b00_0000_1000,
		S_DIFF    = 10'b00_0001_0000,
		S_MX      = 10'b00_0010_0000,
		S_MY      = 10'b00_0100_0000,
		S_CMP     = 10'b00_1000_0000,
		S_ROOT_GO = 10'b01_0000_0000,
		S_ROOT_WT = 10'b10_0000_0000
	} state_t;

	// Handshake between the sequencer and the root unit.
	typedef struct packed {
		logic go;
		logic done;
	} root_ctl_t;

endpackage
`default_nettype wire

### rtl/cpd_ram.sv
`default_nettype none
module cpd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/cpd_sqrt.sv
`default_nettype none
module cpd_sqrt import cpd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [SQ_W-1:0]   radicand,
	output logic                   done,
	output logic      [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] iter_q;
	logic              run_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// One root bit per cycle: bring down two radicand bits and try the next digit.
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the radicand is scaled by 2^(2*FRAC_W) for the fraction bits.
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= {{(RAD_W-SQ_W-2*FRAC_W){1'b0}}, radicand, {(2*FRAC_W){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

### rtl/closest_pair_distance.sv
// While loading, busy stays low and a point transfers every cycle.
// After the last point the search reads and captures each outer point i, then for each pair i < j reads point j,
// takes the differences, squares them on the single shared multiplier and compares against the minimum.
// The square root is then taken in the bit-serial root unit; done rises in the cycle after it finishes.
// With fewer than two points the result comes in the cycle after the last point.
// arst_n clears the point count, overflow flag and sequencer; the store needs no clearing.
`default_nettype none
`include "closest_pair_distance_assert.svh"
module closest_pair_distance import cpd_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      last_point,
	output logic                           done,
	output logic             [SQ_W-1:0]    min_sq_distance,
	output logic             [ROOT_W-1:0]  min_distance_fixed,
	output logic                           pair_found,
	output logic                           set_overflow
);

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic [SQ_W-1:0]     best_q;
	logic [ADDR_W-1:0]   i_q;
	logic [ADDR_W-1:0]   j_q;
	logic [COORD_W-1:0]  xi_q;
	logic [COORD_W-1:0]  yi_q;
	logic [COORD_W-1:0]  dx_q;
	logic [COORD_W-1:0]  dy_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   acc_q;
	logic                done_q;

	logic                accept;
	logic                has_room;
	logic                wr_en;
	logic [CNT_W-1:0]    count_new;
	logic [ADDR_W-1:0]   raddr;
	logic [COORD_W-1:0]  rd_x;
	logic [COORD_W-1:0]  rd_y;
	logic [DIFF_W-1:0]   diff_x;
	logic [DIFF_W-1:0]   diff_y;
	logic [COORD_W-1:0]  abs_x;
	logic [COORD_W-1:0]  abs_y;
	logic [COORD_W-1:0]  mul_a;
	logic [SQ_W-1:0]     sum;
	logic                last_j;
	logic                last_i;
	root_ctl_t           root_ctl;
	logic [ROOT_W-1:0]   root;

	assign busy     = (state_q != S_LOAD);
	assign accept   = start && !busy;
	assign has_room = (count_q < CNT_W'(MAX_POINTS));
	assign wr_en    = accept && has_room;
	assign count_new = has_room ? count_q + 1'b1 : count_q;

	// Point store, one RAM per coordinate; write at the fill count, read at i or j.
	assign raddr = (state_q == S_IRD) ? i_q : j_q;

	cpd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (point_x),
		.raddr (raddr),
		.rdata (rd_x)
	);

	cpd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (point_y),
		.raddr (raddr),
		.rdata (rd_y)
	);

	// Absolute coordinate differences between point i and the point just read.
	always_comb begin
		diff_x = {xi_q[COORD_W-1], xi_q} - {rd_x[COORD_W-1], rd_x};
		diff_y = {yi_q[COORD_W-1], yi_q} - {rd_y[COORD_W-1], rd_y};
		abs_x  = diff_x[DIFF_W-1] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
		abs_y  = diff_y[DIFF_W-1] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
	end

	// Shared squarer operand, and the sum of both squares.
	assign mul_a  = (state_q == S_MY) ? dy_q : dx_q;
	assign sum    = {1'b0, acc_q} + {1'b0, prod_q};
	assign last_j = (({1'b0, j_q} + 1'b1) == count_q);
	assign last_i = (({1'b0, i_q} + CNT_W'(2)) == count_q);

	assign root_ctl.go = (state_q == S_ROOT_GO);

	cpd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (root_ctl.go),
		.radicand (best_q),
		.done     (root_ctl.done),
		.root     (root)
	);

	// Sequencer: load points, then, with two or more points, walk every pair i < j and take the root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (last_point && (count_new < CNT_W'(2))) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							done_q  <= 1'b1;
						end else begin
							count_q <= count_new;
							ovf_q   <= ovf_q || !has_room;
							if (last_point) begin
								i_q     <= '0;
								state_q <= S_IRD;
							end
						end
					end
				end
				S_IRD: begin
					state_q <= S_ICAP;
				end
				S_ICAP: begin
					j_q     <= i_q + 1'b1;
					state_q <= S_JRD;
				end
				S_JRD: begin
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_MX;
				end
				S_MX: begin
					state_q <= S_MY;
				end
				S_MY: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (last_j) begin
						if (last_i) begin
							state_q <= S_ROOT_GO;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_IRD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_JRD;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT_WT;
				end
				S_ROOT_WT: begin
					if (root_ctl.done) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Running minimum; it starts at all ones for each set.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			best_q <= '1;
		end else if (state_q == S_CMP && sum < best_q) begin
			best_q <= sum;
		end
	end

	// Pair datapath around the shared squarer.
	always_ff @(posedge clk) begin
		if (state_q == S_ICAP) begin
			xi_q <= rd_x;
			yi_q <= rd_y;
		end
		if (state_q == S_DIFF) begin
			dx_q <= abs_x;
			dy_q <= abs_y;
		end
		if (state_q == S_MY) begin
			acc_q <= prod_q;
		end
		prod_q <= {{(PROD_W-COORD_W){1'b0}}, mul_a} * {{(PROD_W-COORD_W){1'b0}}, mul_a};
	end

	// Result registers, shown for the one cycle that done is high.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && accept && last_point && count_new < CNT_W'(2)) begin
			min_sq_distance    <= '0;
			min_distance_fixed <= '0;
			pair_found         <= 1'b0;
			set_overflow       <= ovf_q || !has_room;
		end else if (state_q == S_ROOT_WT && root_ctl.done) begin
			min_sq_distance    <= best_q;
			min_distance_fixed <= root;
			pair_found         <= 1'b1;
			set_overflow       <= ovf_q;
		end
	end

	assign done = done_q;

	`CPD_ASSERT_NEXT(a_last_starts_search, accept && last_point && count_new >= CNT_W'(2), busy, "last point did not start the search")
	`CPD_ASSERT_NOW(a_pair_ordered, state_q == S_CMP, j_q > i_q, "pair indices out of order")
	`CPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_POINTS), "point count beyond store size")
	`CPD_ASSERT_NOW(a_empty_result, done && !pair_found, min_sq_distance == '0 && min_distance_fixed == '0, "result without a pair is not zero")

endmodule
`default_nettype wire

### tb/closest_pair_checker.sv
module closest_pair_checker import cpd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      last_point,
	input  logic                      done,
	input  logic        [SQ_W-1:0]    min_sq_distance,
	input  logic        [ROOT_W-1:0]  min_distance_fixed,
	input  logic                      pair_found,
	input  logic                      set_overflow,
	output int                        fail_count,
	output int                        pending,
	output int                        results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SQ_W-1:0]   sq;
		logic [ROOT_W-1:0] root;
		logic              found;
		logic              dropped;
	} pair_result_t;

	// Expected results, oldest first.
	pair_result_t nearest_q[$];

	// Private copy of the point set being loaded.
	logic signed [COORD_W-1:0] x_mem [MAX_POINTS];
	logic signed [COORD_W-1:0] y_mem [MAX_POINTS];
	int   held        = 0;
	logic dropped_pt  = 1'b0;
	int   errs        = 0;
	int   checked     = 0;

	// Smallest squared distance over every pair of held points.
	function automatic logic [SQ_W-1:0] nearest_sq();
		logic [SQ_W-1:0] best;
		longint dx;
		longint dy;
		longint d;
		int i;
		int j;
		best = '1;
		for (i = 0; i < held; i++) begin
			for (j = i + 1; j < held; j++) begin
				dx = longint'(x_mem[i]) - longint'(x_mem[j]);
				dy = longint'(y_mem[i]) - longint'(y_mem[j]);
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				d = dx * dx + dy * dy;
				if (SQ_W'(d) < best) best = SQ_W'(d);
			end
		end
		return best;
	endfunction

	// floor(sqrt(v) * 2^16) equals floor(sqrt(v * 2^32)); found bit by bit, high bit first.
	function automatic logic [ROOT_W-1:0] fixed_root(input logic [SQ_W-1:0] v);
		logic [95:0]       rad;
		logic [95:0]       prod;
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] t;
		int b;
		rad = {1'b0, v, 32'h0};
		r = '0;
		for (b = ROOT_W - 1; b >= 0; b--) begin
			t = r | (ROOT_W'(1) << b);
			prod = {48'h0, t} * {48'h0, t};
			if (prod <= rad) r = t;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n) begin
			// A result strobe is matched against the oldest expectation.
			if (done) begin
				if (nearest_q.size() == 0) begin
					$error("result strobe with no result expected");
					errs++;
				end else begin
					want = nearest_q.pop_front();
					check_field("min_sq_distance", 64'(want.sq), 64'(min_sq_distance));
					check_field("min_distance_fixed", 64'(want.root), 64'(min_distance_fixed));
					check_field("pair_found", 64'(want.found), 64'(pair_found));
					check_field("set_overflow", 64'(want.dropped), 64'(set_overflow));
					checked++;
				end
			end

			// Point transfer: store it, or note the drop once the store is full.
			if (start && !busy) begin
				if (held < MAX_POINTS) begin
					x_mem[held] = point_x;
					y_mem[held] = point_y;
					held++;
				end else begin
					dropped_pt = 1'b1;
				end
				if (last_point) begin
					want.found   = (held >= 2);
					want.sq      = want.found ? nearest_sq() : '0;
					want.root    = want.found ? fixed_root(want.sq) : '0;
					want.dropped = dropped_pt;
					nearest_q.push_back(want);
					held       = 0;
					dropped_pt = 1'b0;
				end
			end
		end
		pending         <= nearest_q.size();
		fail_count      <= errs;
		results_checked <= checked;
	end

endmodule

### tb/tb_closest_pair_distance.sv
module tb_closest_pair_distance;
	timeunit 1ns;
	timeprecision 1ps;
	import cpd_pkg::*;

	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int RANDOM_ITEMS = 120;
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	// How the coordinates of one random set are spread.
	typedef enum int {SPREAD, CLUSTER, CORNERS, TIGHT} coord_mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      last_point;
	logic                      done;
	logic        [SQ_W-1:0]    min_sq_distance;
	logic        [ROOT_W-1:0]  min_distance_fixed;
	logic                      pair_found;
	logic                      set_overflow;

	int fail_count;
	int pending;
	int results_checked;
	int cycles      = 0;
	int n_points    = 0;
	int n_sets      = 0;
	int biggest_set = 0;
	bit quiet       = 1'b0;

	closest_pair_distance dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.point_x            (point_x),
		.point_y            (point_y),
		.last_point         (last_point),
		.done               (done),
		.min_sq_distance    (min_sq_distance),
		.min_distance_fixed (min_distance_fixed),
		.pair_found         (pair_found),
		.set_overflow       (set_overflow)
	);

	closest_pair_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.point_x            (point_x),
		.point_y            (point_y),
		.last_point         (last_point),
		.done               (done),
		.min_sq_distance    (min_sq_distance),
		.min_distance_fixed (min_distance_fixed),
		.pair_found         (pair_found),
		.set_overflow       (set_overflow),
		.fail_count         (fail_count),
		.pending            (pending),
		.results_checked    (results_checked)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one point and wait for its transfer, sometimes idling first.
	task automatic put_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic fin);
		if (!quiet && $urandom_range(0, 99) < 2) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start      <= 1'b1;
		point_x    <= x;
		point_y    <= y;
		last_point <= fin;
		do @(posedge clk); while (busy);
		n_points++;
		if (fin) n_sets++;
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord(input coord_mix_t mix,
			input logic signed [COORD_W-1:0] base);
		logic signed [COORD_W-1:0] v;
		case (mix)
			SPREAD: begin
				v = COORD_W'($urandom);
			end
			CLUSTER: begin
				v = base + COORD_W'($urandom_range(0, 30));
				v = v - COORD_W'(15);
			end
			CORNERS: begin
				case ($urandom_range(0, 4))
					0: v = C_MIN;
					1: v = C_MAX;
					2: v = '0;
					3: v = '1;
					default: v = COORD_W'($urandom);
				endcase
			end
			default: begin
				v = COORD_W'($urandom_range(0, 8));
				v = v - COORD_W'(4);
			end
		endcase
		return v;
	endfunction

	initial begin
		int size;
		int k;
		int r;
		coord_mix_t mix;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;

		arst_n     = 1'b0;
		start      = 1'b0;
		point_x    = '0;
		point_y    = '0;
		last_point = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: lone point, extreme spans, coincident points, small shapes.
		put_point(C_MIN, C_MAX, 1'b1);
		put_point(C_MIN, C_MIN, 1'b0);
		put_point(C_MAX, C_MAX, 1'b1);
		put_point(C_MAX, C_MIN, 1'b0);
		put_point(C_MAX, C_MIN, 1'b1);
		put_point(C_MIN, C_MAX, 1'b0);
		put_point(C_MAX, C_MIN, 1'b1);
		put_point(-31'sd5, 31'sd7, 1'b0);
		put_point(31'sd3, 31'sd7, 1'b0);
		put_point(31'sd100, 31'sd100, 1'b0);
		put_point(-31'sd1, -31'sd1, 1'b1);
		put_point(31'sd0, 31'sd0, 1'b0);
		put_point(31'sd10, 31'sd0, 1'b0);
		put_point(31'sd0, 31'sd10, 1'b0);
		put_point(31'sd7, 31'sd7, 1'b0);
		put_point(-31'sd1, -31'sd1, 1'b1);
		put_point(31'sd0, 31'sd0, 1'b1);
		// The nearest pair is the final two points.
		put_point(C_MAX, 31'sd0, 1'b0);
		put_point(C_MIN, 31'sd0, 1'b0);
		put_point(C_MIN + 31'sd1, 31'sd1, 1'b1);
		if (biggest_set < 5) biggest_set = 5;

		// Random sets, mostly small.
		while (n_points < RANDOM_ITEMS + 20) begin
			r = $urandom_range(0, 99);
			if (r < 5) size = 1;
			else if (r < 80) size = $urandom_range(2, 8);
			else if (r < 95) size = $urandom_range(9, 20);
			else size = $urandom_range(21, 48);
			if (size > biggest_set) biggest_set = size;
			mix = coord_mix_t'($urandom_range(0, 3));
			bx = COORD_W'($urandom);
			by = COORD_W'($urandom);
			for (k = 0; k < size; k++) begin
				put_point(pick_coord(mix, bx), pick_coord(mix, by), k == size - 1);
			end
		end

		// One set past the store size; the dropped points repeat the first one,
		// so storing them would give a zero distance. Its middle runs with no idling.
		fx = COORD_W'($urandom);
		fy = COORD_W'($urandom);
		for (k = 0; k < MAX_POINTS + 2; k++) begin
			quiet = (k >= 200 && k < 600);
			if (k == 0 || k >= MAX_POINTS) put_point(fx, fy, k == MAX_POINTS + 1);
			else put_point(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
		end
		quiet = 1'b0;
		biggest_set = MAX_POINTS + 2;

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d points in %0d sets, largest set %0d points including one overflow set.",
			n_points, n_sets, biggest_set);
		$display("Checked %0d results against the predicted nearest pair.", results_checked);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/cpd_pkg.sv
rtl/cpd_ram.sv
rtl/cpd_sqrt.sv
rtl/closest_pair_distance.sv
tb/closest_pair_checker.sv
tb/tb_closest_pair_distance.sv
